// ----- sv/lcdspi_pkg.sv -----
`default_nettype none

package lcdspi_pkg;

    // Request kinds carried on the slave-side tuser
    typedef enum logic [1:0] {
        ACT_COMMAND   = 2'd0,
        ACT_PARAMETER = 2'd1,
        ACT_PIXEL     = 2'd2,
        ACT_WINDOW    = 2'd3
    } action_t;

    localparam int unsigned BYTE_BITS  = 8;
    localparam int unsigned FRAME_BITS = BYTE_BITS + 1;
    localparam int unsigned MAX_FRAMES = 11;
    localparam int unsigned SHIFT_W    = FRAME_BITS * MAX_FRAMES;
    localparam int unsigned CNT_W      = 4;   // holds 0..MAX_FRAMES
    localparam int unsigned BIT_CNT_W  = 4;   // holds 0..FRAME_BITS-1

    localparam logic [BYTE_BITS-1:0] CMD_COLUMN_ADDR = 8'h2A;
    localparam logic [BYTE_BITS-1:0] CMD_ROW_ADDR    = 8'h2B;
    localparam logic [BYTE_BITS-1:0] CMD_MEM_WRITE   = 8'h2C;

    localparam logic DC_COMMAND = 1'b0;
    localparam logic DC_DATA    = 1'b1;

    localparam logic [CNT_W-1:0] FRAMES_SINGLE = 4'd1;
    localparam logic [CNT_W-1:0] FRAMES_PIXEL  = 4'd3;
    localparam logic [CNT_W-1:0] FRAMES_WINDOW = 4'd11;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = 4'd8;

endpackage

`default_nettype wire

// ----- sv/lcd_three_wire_spi_framer.sv -----
`default_nettype none

// An accepted request loads the frame shifter; each frame is shifted bit by bit, then moved into the output register.
// Throughput: one bit of the 9-bit frame shifted per cycle while the shifter is not held.
// The serial frame shifter sets the rate; it stalls only while a finished frame
//   cannot move into the full output register.
// Reset (rst_n low, asynchronous): no frame pending, output invalid, ready to accept.
module lcd_three_wire_spi_framer (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // [7:0] byte_value, [23:8] pixel_rgb565, [39:24] column_start,
    // [55:40] column_end, [71:56] row_start, [87:72] row_end
    input  wire logic [87:0] s_axis_tdata,
    // [1:0] action
    input  wire logic [1:0]  s_axis_tuser,

    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] frame_byte, [8] release_select, [15:9] zero
    output      logic [15:0] m_axis_tdata,
    // [0] is_data
    output      logic        m_axis_tuser,
    output      logic        m_axis_tlast
);

    localparam int unsigned BB = lcdspi_pkg::BYTE_BITS;
    localparam int unsigned SW = lcdspi_pkg::SHIFT_W;

    // Unpacked request fields
    logic [BB-1:0] byte_value;
    logic [15:0]   pixel_rgb565;
    logic [15:0]   column_start;
    logic [15:0]   column_end;
    logic [15:0]   row_start;
    logic [15:0]   row_end;

    assign byte_value   = s_axis_tdata[7:0];
    assign pixel_rgb565 = s_axis_tdata[23:8];
    assign column_start = s_axis_tdata[39:24];
    assign column_end   = s_axis_tdata[55:40];
    assign row_start    = s_axis_tdata[71:56];
    assign row_end      = s_axis_tdata[87:72];

    // Frame shifter: all frames of the request, first frame in the top bits,
    // each frame as {dc, byte}. The top bit leaves in every cycle that the shifter is enabled.
    logic [SW-1:0]                        shift_reg, shift_next;
    logic [BB-1:0]                        asm_reg, asm_next;     // dc + 7 byte bits
    logic [lcdspi_pkg::BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [lcdspi_pkg::CNT_W-1:0]         frames_left_reg, frames_left_next;
    logic                                 pixel_reg, pixel_next;

    // Output register
    logic          m_valid_reg, m_valid_next;
    logic [BB-1:0] m_byte_reg, m_byte_next;
    logic          m_release_reg, m_release_next;
    logic          m_is_data_reg, m_is_data_next;
    logic          m_last_reg, m_last_next;

    logic          busy;
    logic          out_free;
    logic          on_last_bit;
    logic          shift_en;
    logic          frame_done;
    logic          in_accept;
    logic [SW-1:0] load_word;
    logic [lcdspi_pkg::CNT_W-1:0] load_count;
    logic          load_pixel;
    logic [BB-1:0] red_byte, green_byte, blue_byte;

    assign busy        = (frames_left_reg != '0);
    assign out_free    = !m_valid_reg || m_axis_tready;
    assign on_last_bit = (bit_cnt_reg == lcdspi_pkg::LAST_BIT);
    // Hold the shifter on the final bit until the output register can take the frame
    assign shift_en    = busy && (!on_last_bit || out_free);
    assign frame_done  = busy && on_last_bit && out_free;

    // Accept while idle, or in the cycle the final frame leaves the shifter
    assign s_axis_tready = !busy ||
                           (frame_done && frames_left_reg == lcdspi_pkg::FRAMES_SINGLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // RGB565 to left-aligned RGB666 bytes
    assign red_byte   = {pixel_rgb565[15:11], 3'b000};
    assign green_byte = {pixel_rgb565[10:5], 2'b00};
    assign blue_byte  = {pixel_rgb565[4:0], 3'b000};

    always_comb
    begin
        load_word  = '0;
        load_count = lcdspi_pkg::FRAMES_SINGLE;
        load_pixel = 1'b0;
        unique case (lcdspi_pkg::action_t'(s_axis_tuser))
            lcdspi_pkg::ACT_COMMAND:
            begin
                load_word[SW-1 -: lcdspi_pkg::FRAME_BITS] = {lcdspi_pkg::DC_COMMAND, byte_value};
            end
            lcdspi_pkg::ACT_PARAMETER:
            begin
                load_word[SW-1 -: lcdspi_pkg::FRAME_BITS] = {lcdspi_pkg::DC_DATA, byte_value};
            end
            lcdspi_pkg::ACT_PIXEL:
            begin
                load_word[SW-1 -: 3*lcdspi_pkg::FRAME_BITS] =
                    {lcdspi_pkg::DC_DATA, red_byte,
                     lcdspi_pkg::DC_DATA, green_byte,
                     lcdspi_pkg::DC_DATA, blue_byte};
                load_count = lcdspi_pkg::FRAMES_PIXEL;
                load_pixel = 1'b1;
            end
            lcdspi_pkg::ACT_WINDOW:
            begin
                load_word = {lcdspi_pkg::DC_COMMAND, lcdspi_pkg::CMD_COLUMN_ADDR,
                             lcdspi_pkg::DC_DATA, column_start[15:8],
                             lcdspi_pkg::DC_DATA, column_start[7:0],
                             lcdspi_pkg::DC_DATA, column_end[15:8],
                             lcdspi_pkg::DC_DATA, column_end[7:0],
                             lcdspi_pkg::DC_COMMAND, lcdspi_pkg::CMD_ROW_ADDR,
                             lcdspi_pkg::DC_DATA, row_start[15:8],
                             lcdspi_pkg::DC_DATA, row_start[7:0],
                             lcdspi_pkg::DC_DATA, row_end[15:8],
                             lcdspi_pkg::DC_DATA, row_end[7:0],
                             lcdspi_pkg::DC_COMMAND, lcdspi_pkg::CMD_MEM_WRITE};
                load_count = lcdspi_pkg::FRAMES_WINDOW;
            end
            default:
            begin
                load_word = '0;
            end
        endcase
    end

    always_comb
    begin
        shift_next       = shift_reg;
        asm_next         = asm_reg;
        bit_cnt_next     = bit_cnt_reg;
        frames_left_next = frames_left_reg;
        pixel_next       = pixel_reg;

        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_byte_next    = m_byte_reg;
        m_release_next = m_release_reg;
        m_is_data_next = m_is_data_reg;
        m_last_next    = m_last_reg;

        if (shift_en)
        begin
            shift_next = {shift_reg[SW-2:0], 1'b0};
            asm_next   = {asm_reg[BB-2:0], shift_reg[SW-1]};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end

        if (frame_done)
        begin
            // Move the finished frame to the output; last serial bit joins directly
            m_valid_next     = 1'b1;
            m_is_data_next   = asm_reg[BB-1];
            m_byte_next      = {asm_reg[BB-2:0], shift_reg[SW-1]};
            m_last_next      = (frames_left_reg == lcdspi_pkg::FRAMES_SINGLE);
            // Pixel frames keep chip select low until the blue byte
            m_release_next   = !pixel_reg || (frames_left_reg == lcdspi_pkg::FRAMES_SINGLE);
            bit_cnt_next     = '0;
            frames_left_next = frames_left_reg - 1'b1;
        end

        if (in_accept)
        begin
            shift_next       = load_word;
            bit_cnt_next     = '0;
            frames_left_next = load_count;
            pixel_next       = load_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg     <= '0;
            frames_left_reg <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            bit_cnt_reg     <= bit_cnt_next;
            frames_left_reg <= frames_left_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg     <= shift_next;
        asm_reg       <= asm_next;
        pixel_reg     <= pixel_next;
        m_byte_reg    <= m_byte_next;
        m_release_reg <= m_release_next;
        m_is_data_reg <= m_is_data_next;
        m_last_reg    <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0, m_release_reg, m_byte_reg};
    assign m_axis_tuser  = m_is_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // Bit counter never runs past the last bit of a frame
    a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg <= lcdspi_pkg::LAST_BIT)
        else $error("frame bit counter out of range");

    // A request never queues more frames than a window set-up
    a_frames_range: assert property (@(posedge clk) disable iff (!rst_n)
        frames_left_reg <= lcdspi_pkg::FRAMES_WINDOW)
        else $error("frame count out of range");

    // An accepted request starts a fresh frame with work pending
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (busy && bit_cnt_reg == '0))
        else $error("request accepted without loading the shifter");

    // The last frame of a request always releases chip select
    a_last_releases: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[8])
        else $error("final frame keeps chip select low");

    // A new output frame appears only after a complete 9-bit shift
    a_frame_after_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !$past(m_valid_reg && !m_axis_tready) && !$past(!rst_n))
            |-> $past(on_last_bit && busy))
        else $error("output frame without a finished shift");

endmodule

`default_nettype wire

// ----- bench/lcd_frame_checker.sv -----
module lcd_frame_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          failures,
    output int          frames_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                             is_data;
        logic [lcdspi_pkg::BYTE_BITS-1:0] frame_byte;
        logic                             release_select;
        logic                             last_frame;
    } lcd_frame_t;

    lcd_frame_t frames_due[$];

    function automatic void push_frame(logic dc, logic [lcdspi_pkg::BYTE_BITS-1:0] value,
                                       logic rel, logic last);
        lcd_frame_t f;
        f.is_data        = dc;
        f.frame_byte     = value;
        f.release_select = rel;
        f.last_frame     = last;
        frames_due.push_back(f);
    endfunction

    // window bounds go out high byte first, each byte in its own select window
    function automatic void push_bound(logic [15:0] bound);
        push_frame(lcdspi_pkg::DC_DATA, bound[15:8], 1'b1, 1'b0);
        push_frame(lcdspi_pkg::DC_DATA, bound[7:0], 1'b1, 1'b0);
    endfunction

    function automatic void predict_frames(lcdspi_pkg::action_t act, logic [87:0] req);
        logic [7:0]  byte_value;
        logic [15:0] pixel;
        byte_value = req[7:0];
        pixel      = req[23:8];
        case (act)
            lcdspi_pkg::ACT_COMMAND:
                push_frame(lcdspi_pkg::DC_COMMAND, byte_value, 1'b1, 1'b1);
            lcdspi_pkg::ACT_PARAMETER:
                push_frame(lcdspi_pkg::DC_DATA, byte_value, 1'b1, 1'b1);
            lcdspi_pkg::ACT_PIXEL:
            begin
                // widen RGB565 to left-aligned RGB666; hold select low until blue
                push_frame(lcdspi_pkg::DC_DATA, {pixel[15:11], 3'b000}, 1'b0, 1'b0);
                push_frame(lcdspi_pkg::DC_DATA, {pixel[10:5], 2'b00}, 1'b0, 1'b0);
                push_frame(lcdspi_pkg::DC_DATA, {pixel[4:0], 3'b000}, 1'b1, 1'b1);
            end
            default:
            begin
                push_frame(lcdspi_pkg::DC_COMMAND, lcdspi_pkg::CMD_COLUMN_ADDR, 1'b1, 1'b0);
                push_bound(req[39:24]);
                push_bound(req[55:40]);
                push_frame(lcdspi_pkg::DC_COMMAND, lcdspi_pkg::CMD_ROW_ADDR, 1'b1, 1'b0);
                push_bound(req[71:56]);
                push_bound(req[87:72]);
                push_frame(lcdspi_pkg::DC_COMMAND, lcdspi_pkg::CMD_MEM_WRITE, 1'b1, 1'b1);
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lcd_frame_t want;
        lcd_frame_t got;
        if (!rst_n)
        begin
            frames_due.delete();
            failures           = 0;
            frames_outstanding = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_frames(lcdspi_pkg::action_t'(s_axis_tuser), s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.is_data        = m_axis_tuser;
                got.frame_byte     = m_axis_tdata[7:0];
                got.release_select = m_axis_tdata[8];
                got.last_frame     = m_axis_tlast;
                if (frames_due.size() == 0)
                begin
                    $display("%0t: unexpected frame dc=%0b byte=%02h rel=%0b last=%0b",
                             $realtime, got.is_data, got.frame_byte, got.release_select,
                             got.last_frame);
                    failures = failures + 1;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (got !== want || m_axis_tdata[15:9] !== 7'd0)
                    begin
                        $display("%0t: frame mismatch: expected dc=%0b byte=%02h %s%0b",
                                 $realtime, want.is_data, want.frame_byte,
                                 "rel=", want.release_select);
                        $display("%0t:   expected last=%0b", $realtime, want.last_frame);
                        $display("%0t:   actual dc=%0b byte=%02h rel=%0b last=%0b pad=%02h",
                                 $realtime, got.is_data, got.frame_byte,
                                 got.release_select, got.last_frame, m_axis_tdata[15:9]);
                        failures = failures + 1;
                    end
                end
            end
            frames_outstanding = frames_due.size();
        end
    end

endmodule

// ----- bench/lcd_three_wire_spi_framer_test.sv -----
module lcd_three_wire_spi_framer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 20;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_ITEMS   = 73;
    localparam int DRAIN_CYCLES  = 30;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [7:0] byte_value, [23:8] pixel_rgb565, [39:24] column_start,
    // [55:40] column_end, [71:56] row_start, [87:72] row_end
    logic [87:0] s_axis_tdata = '0;
    // [1:0] action
    logic [1:0]  s_axis_tuser = lcdspi_pkg::ACT_COMMAND;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] frame_byte, [8] release_select, [15:9] zero
    logic [15:0] m_axis_tdata;
    // [0] is_data
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int failures;
    int frames_outstanding;
    int cycle_count = 0;

    // percent chance per cycle that the sender idles / the receiver stalls
    int idle_pct  = 0;
    int stall_pct = 0;

    int sender_idle_by_phase[4]   = '{0, 78, 0, 20};
    int receiver_stall_by_phase[4] = '{0, 0, 78, 20};

    lcd_three_wire_spi_framer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Watch both channels, predict the frame stream and count mismatches.
    lcd_frame_checker frame_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .s_axis_tvalid      (s_axis_tvalid),
        .s_axis_tready      (s_axis_tready),
        .s_axis_tdata       (s_axis_tdata),
        .s_axis_tuser       (s_axis_tuser),
        .m_axis_tvalid      (m_axis_tvalid),
        .m_axis_tready      (m_axis_tready),
        .m_axis_tdata       (m_axis_tdata),
        .m_axis_tuser       (m_axis_tuser),
        .m_axis_tlast       (m_axis_tlast),
        .failures           (failures),
        .frames_outstanding (frames_outstanding)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Drop tready at random on the falling edge, per the current stall rate.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // Abort a hung run: no correct run gets anywhere near this many cycles.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [87:0] pack_request(logic [7:0] byte_value, logic [15:0] pixel,
                                                 logic [15:0] col_first, logic [15:0] col_last,
                                                 logic [15:0] row_first, logic [15:0] row_last);
        return {row_last, row_first, col_last, col_first, pixel, byte_value};
    endfunction

    // Fill every field with random bits; the action picks which ones matter.
    function automatic logic [87:0] random_payload();
        logic [95:0] bits;
        bits = {$urandom(), $urandom(), $urandom()};
        return bits[87:0];
    endfunction

    // Favor pixels, the common request; keep window set-ups rarer since they are long.
    function automatic lcdspi_pkg::action_t pick_action();
        int roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return lcdspi_pkg::ACT_COMMAND;
        else if (roll < 45)
            return lcdspi_pkg::ACT_PARAMETER;
        else if (roll < 85)
            return lcdspi_pkg::ACT_PIXEL;
        else
            return lcdspi_pkg::ACT_WINDOW;
    endfunction

    // Present one request on the falling edge and hold it until the block takes it.
    // Enter and leave on a falling edge, so tvalid stays high between back-to-back requests.
    task automatic send_request(lcdspi_pkg::action_t act, logic [87:0] payload);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= payload;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: byte extremes and more for commands and parameters; ignored fields vary.
        send_request(lcdspi_pkg::ACT_COMMAND,
                     pack_request(8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_request(lcdspi_pkg::ACT_COMMAND,
                     pack_request(8'hFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_request(lcdspi_pkg::ACT_COMMAND,
                     pack_request(lcdspi_pkg::CMD_MEM_WRITE, 16'h1234, 16'h0, 16'h0,
                                  16'h0, 16'h0));
        send_request(lcdspi_pkg::ACT_PARAMETER,
                     pack_request(8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_request(lcdspi_pkg::ACT_PARAMETER,
                     pack_request(8'hFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_request(lcdspi_pkg::ACT_PARAMETER,
                     pack_request(8'hA5, 16'h5A5A, 16'h0, 16'h0, 16'h0, 16'h0));

        // Pixels: black, white, each pure channel at full scale, alternating bits.
        send_request(lcdspi_pkg::ACT_PIXEL,
                     pack_request(8'hFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_request(lcdspi_pkg::ACT_PIXEL,
                     pack_request(8'h00, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0));
        send_request(lcdspi_pkg::ACT_PIXEL,
                     pack_request(8'h00, 16'hF800, 16'h0, 16'h0, 16'h0, 16'h0));
        send_request(lcdspi_pkg::ACT_PIXEL,
                     pack_request(8'h00, 16'h07E0, 16'h0, 16'h0, 16'h0, 16'h0));
        send_request(lcdspi_pkg::ACT_PIXEL,
                     pack_request(8'h00, 16'h001F, 16'h0, 16'h0, 16'h0, 16'h0));
        send_request(lcdspi_pkg::ACT_PIXEL,
                     pack_request(8'h00, 16'h5555, 16'h0, 16'h0, 16'h0, 16'h0));
        send_request(lcdspi_pkg::ACT_PIXEL,
                     pack_request(8'h00, 16'hAAAA, 16'h0, 16'h0, 16'h0, 16'h0));

        // Windows: all-zero bounds, all-ones bounds, distinct bytes in every slot, then a full 240x320 screen.
        send_request(lcdspi_pkg::ACT_WINDOW,
                     pack_request(8'hFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_request(lcdspi_pkg::ACT_WINDOW,
                     pack_request(8'h00, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_request(lcdspi_pkg::ACT_WINDOW,
                     pack_request(8'h3C, 16'hC3C3, 16'h0102, 16'h0304, 16'h0506, 16'h0708));
        send_request(lcdspi_pkg::ACT_WINDOW,
                     pack_request(8'h00, 16'h0000, 16'h0000, 16'h00EF, 16'h0000, 16'h013F));

        // Random requests in four flow-control phases: free-running, slow sender,
        // slow receiver, then both sides gapping.
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct  = sender_idle_by_phase[phase];
            stall_pct = receiver_stall_by_phase[phase];
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(pick_action(), random_payload());
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every predicted frame, then let the shifter settle.
        while (frames_outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
